### rtl/first_fit_segment_allocator_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit segment allocator
// Shared assertion forms, clocked on aclk and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH

// Check a condition at every edge out of reset.
`define FFSA_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check a consequence with non-overlapping implication from the antecedent.
`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ffsa_pkg.sv
// ---------------------------------------------------------------------------
// ffsa_pkg
// Types, constants and command codes of the first-fit segment allocator.
// ---------------------------------------------------------------------------
package ffsa_pkg;

    localparam int MAX_SEGMENTS = 1024;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = IDX_W + 1;

    localparam logic [23:0] POOL_BYTES = 24'hF40000;
    localparam logic [31:0] BASE_RESET = 32'h0400_0000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFIT    = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // read address select
    localparam logic [2:0] RD_IDX  = 3'd0;
    localparam logic [2:0] RD_PTR  = 3'd1;
    localparam logic [2:0] RD_NEXT = 3'd2;
    localparam logic [2:0] RD_PREV = 3'd3;
    localparam logic [2:0] RD_SRC  = 3'd4;

    // write select
    localparam logic [2:0] WR_NONE = 3'd0;
    localparam logic [2:0] WR_INIT = 3'd1;
    localparam logic [2:0] WR_MARK = 3'd2;
    localparam logic [2:0] WR_UP   = 3'd3;
    localparam logic [2:0] WR_SPA  = 3'd4;
    localparam logic [2:0] WR_SPB  = 3'd5;
    localparam logic [2:0] WR_FREE = 3'd6;
    localparam logic [2:0] WR_DN   = 3'd7;

    typedef struct packed {
        logic        opcode;
        logic [23:0] request_size;
        logic [31:0] release_address;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_address;
    } rsp_t;

    typedef struct packed {
        logic [23:0] offset;
        logic [23:0] size;
        logic        used;
    } seg_t;

    typedef struct packed {
        logic [2:0] rd_sel;
        logic [2:0] wr_sel;
        logic       load_req;
        logic       idx_inc;
        logic       ptr_load;
        logic       ptr_dec;
        logic       cur_load;
        logic       next_merge;
        logic       prev_merge;
        logic       rm_setup;
        logic       mv_inc;
        logic       cnt_inc;
        logic       cnt_sub;
        logic       res_load;
        logic       res_grant;
        logic [2:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic in_zero;
        logic is_free;
        logic idx_ge_cnt;
        logic alloc_hit;
        logic exact;
        logic free_hit;
        logic full;
        logic ptr_eq_idx;
        logic next_exists;
        logic idx_zero;
        logic rm_none;
        logic src_ge_cnt;
        logic out_busy;
    } stat_t;

endpackage

### rtl/ffsa_dpath.sv
// ---------------------------------------------------------------------------
// ffsa_dpath
// Segment table memory, pointers, segment count, merge arithmetic and the
// result register.
// ---------------------------------------------------------------------------
module ffsa_dpath
    import ffsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  req_t        s_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_data,
    input  cmd_t        cmd,
    output stat_t       stat
);

    seg_t mem [MAX_SEGMENTS];
    seg_t rdata_reg;

    logic [31:0]      base_reg;
    logic             op_reg;
    logic [23:0]      req_reg;
    logic [31:0]      off_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic [CNT_W-1:0] src_reg;
    logic [IDX_W-1:0] dst_reg;
    logic [1:0]       rm_reg;
    logic [CNT_W-1:0] cnt_reg;
    seg_t             cur_reg;
    seg_t             aux_reg;
    logic             nfree_reg;
    logic             pfree_reg;
    rsp_t             res_reg;
    logic             m_valid_reg;

    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
    seg_t             wdata;
    logic             we;
    logic [IDX_W-1:0] dst_next;
    logic [1:0]       rm_next;

    assign idx_a     = idx_reg[IDX_W-1:0];
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = res_reg;

    always_comb begin
        unique case (cmd.rd_sel)
            RD_PTR:  raddr = ptr_reg;
            RD_NEXT: raddr = idx_a + IDX_W'(1);
            RD_PREV: raddr = idx_a - IDX_W'(1);
            RD_SRC:  raddr = src_reg[IDX_W-1:0];
            default: raddr = idx_a;
        endcase
    end

    always_comb begin
        we    = 1'b1;
        waddr = idx_a;
        wdata = cur_reg;
        unique case (cmd.wr_sel)
            WR_INIT: begin
                waddr = '0;
                wdata = '{offset: 24'd0, size: POOL_BYTES, used: 1'b0};
            end
            WR_MARK: begin
                wdata = '{offset: rdata_reg.offset, size: rdata_reg.size, used: 1'b1};
            end
            WR_UP: begin
                waddr = ptr_reg + IDX_W'(1);
                wdata = rdata_reg;
            end
            WR_SPA: begin
                wdata = '{offset: cur_reg.offset, size: req_reg, used: 1'b1};
            end
            WR_SPB: begin
                waddr = idx_a + IDX_W'(1);
                wdata = '{offset: cur_reg.offset + req_reg,
                          size: cur_reg.size - req_reg, used: 1'b0};
            end
            WR_FREE: begin
                if (pfree_reg) begin
                    waddr = idx_a - IDX_W'(1);
                    wdata = aux_reg;
                end else begin
                    wdata = '{offset: cur_reg.offset, size: cur_reg.size, used: 1'b0};
                end
            end
            WR_DN: begin
                waddr = dst_reg;
                wdata = rdata_reg;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign dst_next = pfree_reg ? idx_a : idx_a + IDX_W'(1);
    assign rm_next  = {1'b0, pfree_reg} + {1'b0, nfree_reg};

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= BASE_RESET;
            cnt_reg     <= CNT_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
            if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (cmd.cnt_sub) begin
                cnt_reg <= cnt_reg - CNT_W'(rm_reg);
            end
            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            op_reg    <= s_data.opcode;
            req_reg   <= s_data.request_size;
            off_reg   <= s_data.release_address - base_reg;
            idx_reg   <= '0;
            nfree_reg <= 1'b0;
            pfree_reg <= 1'b0;
        end
        if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        if (cmd.ptr_load) begin
            ptr_reg <= IDX_W'(cnt_reg - CNT_W'(1));
        end else if (cmd.ptr_dec) begin
            ptr_reg <= ptr_reg - IDX_W'(1);
        end
        if (cmd.cur_load) begin
            cur_reg <= rdata_reg;
        end
        if (cmd.next_merge && !rdata_reg.used) begin
            cur_reg.size <= cur_reg.size + rdata_reg.size;
            nfree_reg    <= 1'b1;
        end
        if (cmd.prev_merge && !rdata_reg.used) begin
            aux_reg   <= '{offset: rdata_reg.offset,
                           size: rdata_reg.size + cur_reg.size, used: 1'b0};
            pfree_reg <= 1'b1;
        end
        if (cmd.rm_setup) begin
            dst_reg <= dst_next;
            rm_reg  <= rm_next;
            src_reg <= {1'b0, dst_next} + CNT_W'(rm_next);
        end else if (cmd.mv_inc) begin
            dst_reg <= dst_reg + IDX_W'(1);
            src_reg <= src_reg + CNT_W'(1);
        end
        if (cmd.res_load) begin
            res_reg.status          <= cmd.res_status;
            res_reg.granted_address <= cmd.res_grant ? base_reg + {8'd0, cur_reg.offset}
                                                     : 32'd0;
        end
    end

    always_comb begin
        stat.in_zero     = (s_data.opcode == OP_ALLOC) && (s_data.request_size == 24'd0);
        stat.is_free     = (op_reg == OP_FREE);
        stat.idx_ge_cnt  = (idx_reg >= cnt_reg);
        stat.alloc_hit   = !rdata_reg.used && (rdata_reg.size >= req_reg);
        stat.exact       = (rdata_reg.size == req_reg);
        stat.free_hit    = ({8'd0, rdata_reg.offset} == off_reg);
        stat.full        = (cnt_reg >= CNT_W'(MAX_SEGMENTS));
        stat.ptr_eq_idx  = ({1'b0, ptr_reg} == idx_reg);
        stat.next_exists = ((idx_reg + CNT_W'(1)) < cnt_reg);
        stat.idx_zero    = (idx_reg == '0);
        stat.rm_none     = !pfree_reg && !nfree_reg;
        stat.src_ge_cnt  = (src_reg >= cnt_reg);
        stat.out_busy    = m_valid_reg && !m_ready;
    end

endmodule

### rtl/ffsa_ctrl.sv
// ---------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer for table scan, insert shift, merge and remove shift.
// ---------------------------------------------------------------------------
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CHK = 4'd3;
    localparam logic [3:0] S_SHU_RD   = 4'd4;
    localparam logic [3:0] S_SHU_WR   = 4'd5;
    localparam logic [3:0] S_SPLIT_A  = 4'd6;
    localparam logic [3:0] S_SPLIT_B  = 4'd7;
    localparam logic [3:0] S_NX_RD    = 4'd8;
    localparam logic [3:0] S_NX_CHK   = 4'd9;
    localparam logic [3:0] S_PV_RD    = 4'd10;
    localparam logic [3:0] S_PV_CHK   = 4'd11;
    localparam logic [3:0] S_FWR      = 4'd12;
    localparam logic [3:0] S_SHD_RD   = 4'd13;
    localparam logic [3:0] S_SHD_WR   = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [2:0] code_reg, code_next;
    logic       grant_reg, grant_next;

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            code_reg  <= ST_OK;
            grant_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
            grant_reg <= grant_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        grant_next = grant_reg;
        cmd        = '0;
        cmd.rd_sel = RD_IDX;
        cmd.wr_sel = WR_NONE;
        unique case (state_reg)
            S_INIT: begin
                cmd.wr_sel = WR_INIT;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    grant_next   = 1'b0;
                    if (stat.in_zero) begin
                        code_next  = ST_ZERO;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (stat.idx_ge_cnt) begin
                    code_next  = stat.is_free ? ST_NOTFOUND : ST_NOFIT;
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                cmd.cur_load = 1'b1;
                if (stat.is_free) begin
                    if (stat.free_hit) begin
                        state_next = S_NX_RD;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_SCAN_RD;
                    end
                end else if (stat.alloc_hit) begin
                    if (stat.exact) begin
                        cmd.wr_sel = WR_MARK;
                        code_next  = ST_OK;
                        grant_next = 1'b1;
                        state_next = S_DONE;
                    end else if (stat.full) begin
                        code_next  = ST_FULL;
                        state_next = S_DONE;
                    end else begin
                        cmd.ptr_load = 1'b1;
                        state_next   = S_SHU_RD;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SHU_RD: begin
                cmd.rd_sel = RD_PTR;
                state_next = S_SHU_WR;
            end
            S_SHU_WR: begin
                cmd.wr_sel = WR_UP;
                if (stat.ptr_eq_idx) begin
                    state_next = S_SPLIT_A;
                end else begin
                    cmd.ptr_dec = 1'b1;
                    state_next  = S_SHU_RD;
                end
            end
            S_SPLIT_A: begin
                cmd.wr_sel = WR_SPA;
                state_next = S_SPLIT_B;
            end
            S_SPLIT_B: begin
                cmd.wr_sel  = WR_SPB;
                cmd.cnt_inc = 1'b1;
                code_next   = ST_OK;
                grant_next  = 1'b1;
                state_next  = S_DONE;
            end
            S_NX_RD: begin
                cmd.rd_sel = RD_NEXT;
                state_next = stat.next_exists ? S_NX_CHK : S_PV_RD;
            end
            S_NX_CHK: begin
                cmd.next_merge = 1'b1;
                state_next     = S_PV_RD;
            end
            S_PV_RD: begin
                cmd.rd_sel = RD_PREV;
                state_next = stat.idx_zero ? S_FWR : S_PV_CHK;
            end
            S_PV_CHK: begin
                cmd.prev_merge = 1'b1;
                state_next     = S_FWR;
            end
            S_FWR: begin
                cmd.wr_sel   = WR_FREE;
                cmd.rm_setup = 1'b1;
                code_next    = ST_OK;
                state_next   = stat.rm_none ? S_DONE : S_SHD_RD;
            end
            S_SHD_RD: begin
                cmd.rd_sel = RD_SRC;
                if (stat.src_ge_cnt) begin
                    cmd.cnt_sub = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_SHD_WR;
                end
            end
            S_SHD_WR: begin
                cmd.wr_sel = WR_DN;
                cmd.mv_inc = 1'b1;
                state_next = S_SHD_RD;
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = code_reg;
                    cmd.res_grant  = grant_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### rtl/first_fit_segment_allocator_unit.sv
// ---------------------------------------------------------------------------
// first_fit_segment_allocator_unit
// First-fit pool allocator with split on allocate and coalescing on free.
// ---------------------------------------------------------------------------
// One request is worked at a time. The segment table lives in a simple
// dual-port style memory (one write, one registered read per cycle), so each
// table entry visited takes a read state and a check state, and each entry
// moved when a split opens a slot or a merge closes one takes a read state
// and a write state. Setup and result hand-off come on top. Since the scan
// stops where the shift starts, the worst case is a request near a full
// table. After reset the block writes the whole-pool entry before s_ready
// rises. The result word sits in an output register; s_ready comes back
// while it waits.
// base_address is written through cfg_*, which is always ready; write it only
// while no request is in flight.
// ---------------------------------------------------------------------------
module first_fit_segment_allocator_unit
    import ffsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  req_t        s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: scan, shift, merge, hand off
    ffsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // table memory, pointers, arithmetic, result word
    ffsa_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

### rtl/ffsa_checker.sv
// ---------------------------------------------------------------------------
// ffsa_checker
// Port-level checks of the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "first_fit_segment_allocator_unit_defines.svh"

module ffsa_checker
    import ffsa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input rsp_t        m_data
);

    `FFSA_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")
    `FFSA_ASSERT_NOW(a_status_range, !m_valid || (m_data.status <= ST_NOTFOUND), "status code out of range")
    `FFSA_ASSERT_NOW(a_addr_zero, !m_valid || (m_data.status == ST_OK) || (m_data.granted_address == 32'd0), "failed request carries an address")
    `FFSA_ASSERT_NEXT(a_one_at_time, s_valid && s_ready, !s_ready, "second request taken while one is in work")

endmodule

bind first_fit_segment_allocator_unit ffsa_checker u_ffsa_checker (.*);
